// ----- src/hht_pkg.sv -----
`timescale 1ns / 1ps

package hht_pkg;

   // Byte values that steer the parser.
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam int unsigned LIMIT_WIDTH = 10;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 10'd255;

   // Token classes.
   localparam logic [3:0] CLS_SKIPPED  = 4'd0;
   localparam logic [3:0] CLS_KEY      = 4'd1;
   localparam logic [3:0] CLS_COLON    = 4'd2;
   localparam logic [3:0] CLS_SPACE    = 4'd3;
   localparam logic [3:0] CLS_VALUE    = 4'd4;
   localparam logic [3:0] CLS_LINE_CR  = 4'd5;
   localparam logic [3:0] CLS_LINE_LF  = 4'd6;
   localparam logic [3:0] CLS_END_CR   = 4'd7;
   localparam logic [3:0] CLS_END_LF   = 4'd8;
   localparam logic [3:0] CLS_IGNORED  = 4'd9;

   // Error codes.
   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_EMPTY_KEY   = 3'd1;
   localparam logic [2:0] ERR_KEY_BREAK   = 3'd2;
   localparam logic [2:0] ERR_NO_SPACE    = 3'd3;
   localparam logic [2:0] ERR_EMPTY_VALUE = 3'd4;
   localparam logic [2:0] ERR_TOO_LONG    = 3'd5;
   localparam logic [2:0] ERR_LINE_CR     = 3'd6;
   localparam logic [2:0] ERR_END_CR      = 3'd7;

   // One result beat.
   typedef struct packed {
      logic [3:0] token_class;
      logic       token_first;
      logic       headers_done;
      logic [2:0] error_code;
   } result_type;

endpackage

// ----- src/hht_parser.sv -----
`timescale 1ns / 1ps

module hht_parser import hht_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [7:0]             data_byte,
   input  logic                   restart,
   input  logic [LIMIT_WIDTH-1:0] value_limit,
   output result_type             result
);

   typedef enum logic [3:0] {
      ST_START  = 4'd0,
      ST_KEY    = 4'd1,
      ST_COLON  = 4'd2,
      ST_SPACE  = 4'd3,
      ST_VALUE  = 4'd4,
      ST_CR     = 4'd5,
      ST_LF     = 4'd6,
      ST_END_CR = 4'd7,
      ST_DONE   = 4'd8,
      ST_ERROR  = 4'd9
   } parse_state_type;

   parse_state_type        state_ff, state_in, cur_state;
   logic [LIMIT_WIDTH-1:0] value_count_ff, value_count_in, cur_count;
   logic                   key_count_ff, key_count_in, cur_key;
   logic [2:0]             error_ff, error_in, cur_error;
   logic                   is_cr, is_lf, is_colon, is_space;

   assign is_cr    = (data_byte == CHAR_CR);
   assign is_lf    = (data_byte == CHAR_LF);
   assign is_colon = (data_byte == CHAR_COLON);
   assign is_space = (data_byte == CHAR_SPACE);

   // A restart beat is handled as if the parser had just come out of reset.
   assign cur_state = restart ? ST_START : state_ff;
   assign cur_count = restart ? '0 : value_count_ff;
   assign cur_key   = restart ? 1'b0 : key_count_ff;
   assign cur_error = restart ? ERR_NONE : error_ff;

   always_comb begin
      state_in           = cur_state;
      value_count_in     = cur_count;
      key_count_in       = cur_key;
      error_in           = cur_error;
      result.token_class = CLS_IGNORED;
      result.token_first = 1'b0;
      result.headers_done = 1'b0;

      unique case (cur_state)
         ST_START, ST_LF: begin
            if (cur_state == ST_START && (is_cr || is_lf)) begin
               result.token_class = CLS_SKIPPED;
            end else if (cur_state == ST_LF && is_cr) begin
               state_in           = ST_END_CR;
               result.token_class = CLS_END_CR;
            end else if (is_colon) begin
               key_count_in = 1'b0;
               state_in     = ST_ERROR;
               error_in     = ERR_EMPTY_KEY;
            end else if (is_cr || is_lf) begin
               key_count_in = 1'b0;
               state_in     = ST_ERROR;
               error_in     = ERR_KEY_BREAK;
            end else begin
               state_in           = ST_KEY;
               key_count_in       = 1'b1;
               result.token_first = 1'b1;
               result.token_class = CLS_KEY;
            end
         end
         ST_KEY: begin
            if (is_colon) begin
               if (!cur_key) begin
                  state_in = ST_ERROR;
                  error_in = ERR_EMPTY_KEY;
               end else begin
                  state_in           = ST_COLON;
                  result.token_class = CLS_COLON;
               end
            end else if (is_cr || is_lf) begin
               state_in = ST_ERROR;
               error_in = ERR_KEY_BREAK;
            end else begin
               key_count_in       = 1'b1;
               result.token_class = CLS_KEY;
            end
         end
         ST_COLON: begin
            if (is_space) begin
               state_in           = ST_SPACE;
               result.token_class = CLS_SPACE;
            end else begin
               state_in = ST_ERROR;
               error_in = ERR_NO_SPACE;
            end
         end
         ST_SPACE: begin
            if (is_cr) begin
               state_in = ST_ERROR;
               error_in = ERR_EMPTY_VALUE;
            end else begin
               state_in           = ST_VALUE;
               value_count_in     = '0;
               result.token_first = 1'b1;
               result.token_class = CLS_VALUE;
            end
         end
         ST_VALUE: begin
            if (is_cr) begin
               state_in           = ST_CR;
               result.token_class = CLS_LINE_CR;
            end else if (cur_count >= value_limit) begin
               state_in = ST_ERROR;
               error_in = ERR_TOO_LONG;
            end else begin
               value_count_in     = cur_count + 1'b1;
               result.token_class = CLS_VALUE;
            end
         end
         ST_CR: begin
            if (is_lf) begin
               state_in           = ST_LF;
               result.token_class = CLS_LINE_LF;
            end else begin
               state_in = ST_ERROR;
               error_in = ERR_LINE_CR;
            end
         end
         ST_END_CR: begin
            if (is_lf) begin
               state_in            = ST_DONE;
               result.headers_done = 1'b1;
               result.token_class  = CLS_END_LF;
            end else begin
               state_in = ST_ERROR;
               error_in = ERR_END_CR;
            end
         end
         default: begin
            // Done, error and unused codes: the byte is ignored.
            result.token_class = CLS_IGNORED;
         end
      endcase

      result.error_code = error_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_START;
         value_count_ff <= '0;
         key_count_ff   <= 1'b0;
         error_ff       <= ERR_NONE;
      end else if (step_en) begin
         state_ff       <= state_in;
         value_count_ff <= value_count_in;
         key_count_ff   <= key_count_in;
         error_ff       <= error_in;
      end
   end

endmodule

// ----- src/http_header_tokenizer.sv -----
`timescale 1ns / 1ps

// HTTP header tokenizer. Each request beat carries one raw byte of an HTTP
// request header block; each response beat tags that byte with its role
// (key, colon, space, value, line break, end of block, skipped or ignored),
// flags the first byte of every key and value, marks the LF that closes the
// empty final line, and reports the sticky syntax error seen so far. There
// is exactly one response beat per request beat, in order. The block takes
// one byte per clock cycle while the response side does not stall: the
// byte is held in an input register, the parser state advances through
// combinational logic, and the tag is held in a result register that drives
// the response side, where it leaves once the response side does not stall.
// The per-byte state update in the parser is the loop that sets this rate.
// While the response side stalls, the block holds two bytes, one in each
// register, and then stalls the request side. A request beat with restart
// set returns the parser to its start state before the byte is handled. The
// value length limit is written through the csr port, which is always
// ready; write it only while no bytes are in flight.

module http_header_tokenizer import hht_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel: raw header bytes.
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_restart,
   // Response channel: one tag per byte.
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [3:0]             rsp_token_class,
   output logic                   rsp_token_first,
   output logic                   rsp_headers_done,
   output logic [2:0]             rsp_error_code,
   // Configuration: value length limit.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [LIMIT_WIDTH-1:0] csr_data
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   in_restart_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff;
   result_type             step_result;
   logic [LIMIT_WIDTH-1:0] value_limit_ff;
   logic                   advance;
   logic                   req_take;
   logic                   step_en;

   // The result register can load when it is empty or its beat leaves now.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   // The input register takes a new beat when it is empty or its own beat moves on.
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign step_en   = in_valid_ff && advance;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = step_en;
      end
   end

   hht_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .data_byte   (in_byte_ff),
      .restart     (in_restart_ff),
      .value_limit (value_limit_ff),
      .result      (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         value_limit_ff <= LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            value_limit_ff <= csr_data;
         end
      end
      // Payload registers carry no reset.
      if (req_take) begin
         in_byte_ff    <= req_data_byte;
         in_restart_ff <= req_restart;
      end
      if (step_en) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_token_class  = rsp_ff.token_class;
   assign rsp_token_first  = rsp_ff.token_first;
   assign rsp_headers_done = rsp_ff.headers_done;
   assign rsp_error_code   = rsp_ff.error_code;

endmodule

// ----- src/hht_checker.sv -----
`timescale 1ns / 1ps

module hht_checker import hht_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [3:0]             rsp_token_class,
   input logic                   rsp_token_first,
   input logic                   rsp_headers_done,
   input logic [2:0]             rsp_error_code
);

   // A stalled response beat stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_class)
         && $stable(rsp_token_first) && $stable(rsp_headers_done)
         && $stable(rsp_error_code))
      else $error("stalled response beat changed");

   // Any sticky error means the byte is ignored.
   a_err_ignored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != ERR_NONE) |-> rsp_token_class == CLS_IGNORED)
      else $error("byte tagged while an error is pending");

   // The end of the block is flagged only on a clean final LF.
   a_done_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_headers_done |->
         rsp_token_class == CLS_END_LF && rsp_error_code == ERR_NONE)
      else $error("headers_done on a byte other than the final LF");

   // Only keys and values have a first byte.
   a_first_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_first |->
         rsp_token_class == CLS_KEY || rsp_token_class == CLS_VALUE)
      else $error("token_first on a byte that is neither key nor value");

endmodule

bind http_header_tokenizer hht_checker u_hht_checker (.*);

// ----- bench/tb_http_header_tokenizer.sv -----
`timescale 1ns / 1ps

module tb_http_header_tokenizer;

   import hht_pkg::*;

   // Bench timing. The watchdog sits far beyond the slowest legal run: long values at
   // the widest limit, the heaviest receiver stall, sender gaps and the long hold-off.
   localparam int CLOCK_PERIOD    = 20;
   localparam int WATCHDOG_CYCLES = 400_000;
   localparam int HOLD_CYCLES     = 300;
   localparam int PHASE_BEATS     = 100;
   localparam int PRINT_LIMIT     = 40;

   // Parser phases of the tracking copy below.
   typedef enum logic [3:0] {
      PH_START, PH_KEY, PH_COLON, PH_SPACE, PH_VALUE,
      PH_LINE_CR, PH_LINE_LF, PH_END_CR, PH_DONE, PH_ERROR
   } parse_phase_type;

   // Ways the receiver can behave for a stretch of cycles.
   typedef enum logic [1:0] {
      STALL_NONE, STALL_PATTERN, STALL_LIGHT, STALL_HEAVY
   } stall_mode_type;

   // One request beat. A pinned row carries a tag that is typed in by hand and
   // replaces the tracked prediction when the byte is accepted.
   typedef struct packed {
      logic [7:0] data;
      logic       restart;
      logic       pinned;
      result_type tag;
   } step_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_data_byte = '0;
   logic                   req_restart = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [3:0]             rsp_token_class;
   logic                   rsp_token_first;
   logic                   rsp_headers_done;
   logic [2:0]             rsp_error_code;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [LIMIT_WIDTH-1:0] csr_data = '0;

   // Side band that travels with each request beat: the hand-typed tag, if any.
   logic       beat_pinned = 1'b0;
   result_type beat_pinned_tag = '0;

   // Tracking copy of the parser, advanced once per accepted byte.
   parse_phase_type        track_phase;
   logic [9:0]             track_value_count;
   logic                   track_key_seen;
   logic [2:0]             track_error;
   logic [LIMIT_WIDTH-1:0] track_limit;

   // Tags owed by the block, oldest first.
   result_type   pending_tags[$];
   step_row_type directed_rows[$];

   int unsigned mismatch_count = 0;
   int unsigned result_index = 0;
   int unsigned sent_beats = 0;
   int          burst_left = 0;
   int          phase_limit = int'(LIMIT_RESET);
   logic        long_pending = 1'b0;
   logic        random_stage = 1'b0;
   logic        hold_off = 1'b0;

   stall_mode_type stall_mode = STALL_NONE;
   int             stall_run = 0;
   logic [31:0]    stall_bits = '0;

   http_header_tokenizer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_class  (rsp_token_class),
      .rsp_token_first  (rsp_token_first),
      .rsp_headers_done (rsp_headers_done),
      .rsp_error_code   (rsp_error_code),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Tracking parser.
   // ------------------------------------------------------------------------

   // Puts the tracking parser back at the start of a header block. The value
   // limit is a register and survives this.
   function automatic void clear_tracking();
      track_phase       = PH_START;
      track_value_count = '0;
      track_key_seen    = 1'b0;
      track_error       = ERR_NONE;
   endfunction

   // Any syntax error parks the parser until the next restart, and the byte
   // that caused it is tagged as ignored.
   function automatic logic [3:0] enter_error(input logic [2:0] code);
      track_error = code;
      track_phase = PH_ERROR;
      return CLS_IGNORED;
   endfunction

   // Works out the tag for one accepted byte and advances the tracking parser.
   function automatic result_type classify_byte(input logic [7:0] b, input logic restart_bit);
      result_type tag;
      tag = '0;
      tag.token_class = CLS_IGNORED;
      if (restart_bit)
         clear_tracking();
      case (track_phase)
         // The start of the block and the start of a later line share the
         // key opening rules. Only the very start skips stray line breaks, and
         // only a later line can open the closing empty line with a CR.
         PH_START, PH_LINE_LF: begin
            if (track_phase == PH_START && (b == CHAR_CR || b == CHAR_LF)) begin
               tag.token_class = CLS_SKIPPED;
            end else if (track_phase == PH_LINE_LF && b == CHAR_CR) begin
               track_phase     = PH_END_CR;
               tag.token_class = CLS_END_CR;
            end else begin
               track_key_seen = 1'b0;
               if (b == CHAR_COLON) begin
                  tag.token_class = enter_error(ERR_EMPTY_KEY);
               end else if (b == CHAR_CR || b == CHAR_LF) begin
                  tag.token_class = enter_error(ERR_KEY_BREAK);
               end else begin
                  track_phase     = PH_KEY;
                  track_key_seen  = 1'b1;
                  tag.token_first = 1'b1;
                  tag.token_class = CLS_KEY;
               end
            end
         end
         PH_KEY: begin
            if (b == CHAR_COLON) begin
               if (!track_key_seen) begin
                  tag.token_class = enter_error(ERR_EMPTY_KEY);
               end else begin
                  track_phase     = PH_COLON;
                  tag.token_class = CLS_COLON;
               end
            end else if (b == CHAR_CR || b == CHAR_LF) begin
               tag.token_class = enter_error(ERR_KEY_BREAK);
            end else begin
               track_key_seen  = 1'b1;
               tag.token_class = CLS_KEY;
            end
         end
         PH_COLON: begin
            if (b == CHAR_SPACE) begin
               track_phase     = PH_SPACE;
               tag.token_class = CLS_SPACE;
            end else begin
               tag.token_class = enter_error(ERR_NO_SPACE);
            end
         end
         PH_SPACE: begin
            if (b == CHAR_CR) begin
               tag.token_class = enter_error(ERR_EMPTY_VALUE);
            end else begin
               track_phase       = PH_VALUE;
               track_value_count = '0;
               tag.token_first   = 1'b1;
               tag.token_class   = CLS_VALUE;
            end
         end
         PH_VALUE: begin
            // The count holds the offset of the last value byte taken, so the
            // next byte sits at count + 1 and must not pass the limit.
            if (b == CHAR_CR) begin
               track_phase     = PH_LINE_CR;
               tag.token_class = CLS_LINE_CR;
            end else if (track_value_count >= track_limit) begin
               tag.token_class = enter_error(ERR_TOO_LONG);
            end else begin
               track_value_count = track_value_count + 1'b1;
               tag.token_class   = CLS_VALUE;
            end
         end
         PH_LINE_CR: begin
            if (b == CHAR_LF) begin
               track_phase     = PH_LINE_LF;
               tag.token_class = CLS_LINE_LF;
            end else begin
               tag.token_class = enter_error(ERR_LINE_CR);
            end
         end
         PH_END_CR: begin
            if (b == CHAR_LF) begin
               track_phase      = PH_DONE;
               tag.headers_done = 1'b1;
               tag.token_class  = CLS_END_LF;
            end else begin
               tag.token_class = enter_error(ERR_END_CR);
            end
         end
         default: begin
            // Done or in error: the byte is ignored and the sticky code stays.
            tag.token_class = CLS_IGNORED;
         end
      endcase
      tag.error_code = track_error;
      return tag;
   endfunction

   // ------------------------------------------------------------------------
   // Scoreboard. Everything is sampled at the rising edge, where the bench's
   // own nonblocking drives and the block's registers still hold the values
   // of the cycle that is ending.
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [3:0] want,
                                  input logic [3:0] got);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t ns: result beat %0d, %s: expected %0d, got %0d",
                  $time, result_index, what, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : scoreboard
      result_type tag;
      result_type want;
      if (reset) begin
         track_limit = LIMIT_RESET;
         clear_tracking();
         pending_tags.delete();
      end else begin
         // Results are checked before this edge's byte is recorded, so a tag
         // can never be matched against its own byte in the same cycle.
         if (rsp_valid && !rsp_stall) begin
            if (pending_tags.size() == 0) begin
               report_mismatch("beat with no byte outstanding, token_class", 4'bx,
                               rsp_token_class);
            end else begin
               want = pending_tags.pop_front();
               if (rsp_token_class !== want.token_class)
                  report_mismatch("token_class", want.token_class, rsp_token_class);
               if (rsp_token_first !== want.token_first)
                  report_mismatch("token_first", want.token_first, rsp_token_first);
               if (rsp_headers_done !== want.headers_done)
                  report_mismatch("headers_done", want.headers_done, rsp_headers_done);
               if (rsp_error_code !== want.error_code)
                  report_mismatch("error_code", want.error_code, rsp_error_code);
            end
            result_index++;
         end
         if (csr_valid && csr_ready)
            track_limit = csr_data;
         if (req_valid && !req_stall) begin
            // The tracking parser always advances; a pinned row only swaps in
            // the tag that was typed in for it.
            tag = classify_byte(req_data_byte, req_restart);
            if (beat_pinned)
               tag = beat_pinned_tag;
            pending_tags.push_back(tag);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver. It switches between quiet stretches, a rotating stall pattern
   // and light or heavy random stalling. The hold-off from the pressure
   // process below overrides all of them.
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_run  <= $urandom_range(24, 160);
         stall_bits <= $urandom;
      end else begin
         stall_run  <= stall_run - 1;
         stall_bits <= {stall_bits[30:0], stall_bits[31]};
      end
      case (stall_mode)
         STALL_PATTERN: rsp_stall <= hold_off | stall_bits[0];
         STALL_LIGHT:   rsp_stall <= hold_off | ($urandom_range(0, 3) == 0);
         STALL_HEAVY:   rsp_stall <= hold_off | ($urandom_range(0, 3) != 0);
         default:       rsp_stall <= hold_off;
      endcase
   end

   // Once the random stage is under way, the receiver refuses every beat for a
   // long stretch while the sender keeps offering bytes. The pipeline fills
   // and the block has to push back on its request side.
   initial begin
      while (!random_stage)
         @(posedge clock);
      repeat ($urandom_range(20, 60)) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Sender.
   // ------------------------------------------------------------------------

   task automatic add_row(input logic [7:0] data, input logic restart_bit);
      step_row_type row;
      row         = '0;
      row.data    = data;
      row.restart = restart_bit;
      directed_rows.push_back(row);
   endtask

   task automatic add_pinned_row(input logic [7:0] data, input logic restart_bit,
                                 input logic [3:0] cls, input logic first_bit,
                                 input logic done_bit, input logic [2:0] err);
      step_row_type row;
      row                  = '0;
      row.data             = data;
      row.restart          = restart_bit;
      row.pinned           = 1'b1;
      row.tag.token_class  = cls;
      row.tag.token_first  = first_bit;
      row.tag.headers_done = done_bit;
      row.tag.error_code   = err;
      directed_rows.push_back(row);
   endtask

   // Offers one beat and returns at the edge that accepts it. Valid stays high
   // from one beat to the next inside a burst; a gap lowers it first.
   task automatic drive_row(input step_row_type row);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_data_byte   <= row.data;
      req_restart     <= row.restart;
      beat_pinned     <= row.pinned;
      beat_pinned_tag <= row.tag;
      do
         @(posedge clock);
      while (req_stall);
      sent_beats++;
   endtask

   // Random byte that favors the characters the parser reacts to.
   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 7))
         0:       return CHAR_CR;
         1:       return CHAR_LF;
         2:       return CHAR_COLON;
         3:       return CHAR_SPACE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Sends one header block. Most are well formed with random keys and values,
   // some get one byte corrupted, and a few are plain noise. Values are short,
   // except that once in each phase after the first one value runs just under,
   // at or just past the limit.
   task automatic send_header_block();
      logic [7:0]   block_bytes[$];
      logic [7:0]   b;
      logic         restart_first;
      int           len;
      step_row_type row;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 16)) block_bytes.push_back(noise_byte());
         restart_first = 1'($urandom_range(0, 1));
      end else begin
         repeat ($urandom_range(0, 2))
            block_bytes.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
         repeat ($urandom_range(1, 4)) begin
            repeat ($urandom_range(1, 6)) begin
               do
                  b = 8'($urandom_range(0, 255));
               while (b == CHAR_COLON || b == CHAR_CR || b == CHAR_LF);
               block_bytes.push_back(b);
            end
            block_bytes.push_back(CHAR_COLON);
            block_bytes.push_back(CHAR_SPACE);
            if (long_pending) begin
               long_pending = 1'b0;
               case ($urandom_range(0, 2))
                  0:       len = phase_limit;
                  1:       len = phase_limit + 1;
                  default: len = phase_limit + 2;
               endcase
            end else begin
               len = $urandom_range(1, 8);
            end
            repeat (len) begin
               // A bare LF inside a value is legal and is kept in the mix.
               if ($urandom_range(0, 15) == 0) begin
                  b = CHAR_LF;
               end else begin
                  do
                     b = 8'($urandom_range(0, 255));
                  while (b == CHAR_CR);
               end
               block_bytes.push_back(b);
            end
            block_bytes.push_back(CHAR_CR);
            block_bytes.push_back(CHAR_LF);
         end
         block_bytes.push_back(CHAR_CR);
         block_bytes.push_back(CHAR_LF);
         // Bytes past the end of the block belong to the request body.
         repeat ($urandom_range(0, 3)) block_bytes.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 4) == 0)
            block_bytes[$urandom_range(0, block_bytes.size() - 1)] = noise_byte();
         restart_first = ($urandom_range(0, 15) != 0);
      end
      foreach (block_bytes[i]) begin
         row         = '0;
         row.data    = block_bytes[i];
         row.restart = (i == 0) ? restart_first : ($urandom_range(0, 199) == 0);
         drive_row(row);
      end
   endtask

   // The limit may only change with no byte inside the block, so the sender
   // stops, every owed tag is collected, and the bench idles before the
   // write. The byte accepted at the current edge is booked by the scoreboard
   // in this same time step, so the queue is first looked at on the falling
   // edge.
   task automatic write_value_limit(input logic [LIMIT_WIDTH-1:0] value);
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_tags.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid   <= 1'b0;
      phase_limit = int'(value);
   endtask

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------

   initial begin
      int unsigned            phase_start;
      logic [LIMIT_WIDTH-1:0] phase_limits[6];

      // Directed header walk. Pinned rows carry tags that follow straight from
      // the protocol: skipped bytes, the first key byte, the closing LF, the
      // byte after the block and the erroring bytes.
      add_pinned_row(CHAR_CR, 1'b1, CLS_SKIPPED, 1'b0, 1'b0, ERR_NONE);
      add_pinned_row(8'h00, 1'b0, CLS_KEY, 1'b1, 1'b0, ERR_NONE);
      add_row(8'hFF, 1'b0);
      add_row(CHAR_COLON, 1'b0);
      add_row(CHAR_SPACE, 1'b0);
      add_row(8'hFF, 1'b0);
      add_row(CHAR_LF, 1'b0);                 // LF inside a value is a value byte.
      add_row(CHAR_CR, 1'b0);
      add_row(CHAR_LF, 1'b0);
      add_row(CHAR_CR, 1'b0);
      add_pinned_row(CHAR_LF, 1'b0, CLS_END_LF, 1'b0, 1'b1, ERR_NONE);
      add_pinned_row(8'h41, 1'b0, CLS_IGNORED, 1'b0, 1'b0, ERR_NONE);
      // A colon opening a line is an empty key, and the error then sticks.
      add_pinned_row(CHAR_COLON, 1'b1, CLS_IGNORED, 1'b0, 1'b0, ERR_EMPTY_KEY);
      add_pinned_row(CHAR_LF, 1'b0, CLS_IGNORED, 1'b0, 1'b0, ERR_EMPTY_KEY);
      // A CR right after the space is an empty value.
      add_row(8'h6B, 1'b1);
      add_row(CHAR_COLON, 1'b0);
      add_row(CHAR_SPACE, 1'b0);
      add_pinned_row(CHAR_CR, 1'b0, CLS_IGNORED, 1'b0, 1'b0, ERR_EMPTY_VALUE);
      // After a full header line, an LF where a key or the final CR belongs is
      // a break in the key.
      add_row(8'h6B, 1'b1);
      add_row(CHAR_COLON, 1'b0);
      add_row(CHAR_SPACE, 1'b0);
      add_row(8'h76, 1'b0);
      add_row(CHAR_CR, 1'b0);
      add_row(CHAR_LF, 1'b0);
      add_pinned_row(CHAR_LF, 1'b0, CLS_IGNORED, 1'b0, 1'b0, ERR_KEY_BREAK);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         drive_row(directed_rows[i]);

      // Random stage. The first phase runs at the reset limit; the others
      // cover both extremes, a tiny limit, a random small one, and the reset
      // value written back explicitly. Each phase after the first sends one
      // value at the edge of its limit.
      random_stage   <= 1'b1;
      phase_limits[0] = LIMIT_RESET;
      phase_limits[1] = LIMIT_WIDTH'(1);
      phase_limits[2] = LIMIT_WIDTH'(1023);
      phase_limits[3] = LIMIT_WIDTH'(2);
      phase_limits[4] = LIMIT_WIDTH'($urandom_range(3, 64));
      phase_limits[5] = LIMIT_RESET;
      for (int p = 0; p < 6; p++) begin
         if (p != 0)
            write_value_limit(phase_limits[p]);
         long_pending = (p != 0);
         phase_start  = sent_beats;
         while (sent_beats - phase_start < PHASE_BEATS)
            send_header_block();
      end

      // Drain: collect every owed tag, then let the block run on idle so that
      // any stray beat shows.
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_tags.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("http_header_tokenizer verification clean");
      else
         $display("http_header_tokenizer verification failed");
      $finish;
   end

   // A hung handshake or a lost beat ends the run here.
   initial begin
      #(CLOCK_PERIOD * WATCHDOG_CYCLES);
      $display("http_header_tokenizer verification failed");
      $finish;
   end

endmodule

// ----- files.f -----
src/hht_pkg.sv
src/hht_parser.sv
src/http_header_tokenizer.sv
src/hht_checker.sv
bench/tb_http_header_tokenizer.sv
